@@ rtl/ffba_pkg.sv @@
package ffba_pkg;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_SIZE  = 2'd2;
	localparam logic [1:0] REQ_INFO  = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOMEM   = 3'd1;
	localparam logic [2:0] ST_ZERO    = 3'd2;
	localparam logic [2:0] ST_BADTAG  = 3'd3;
	localparam logic [2:0] ST_NOTUSED = 3'd4;

	localparam logic [3:0] TAG_MEM = 4'h2;

	localparam logic [0:0] CFG_POOL_BASE  = 1'd0;
	localparam logic [0:0] CFG_POOL_BYTES = 1'd1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SCAN_WAIT,
		S_PREV,
		S_PREV_WAIT,
		S_APPLY,
		S_DONE
	} ffba_state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_start;
		logic clear_step;
		logic load_req;
		logic scan_start;
		logic scan_step;
		logic prev_start;
		logic prev_step;
		logic apply;
		logic finish;
	} ffba_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic decode_ok;
		logic scan_done;
		logic prev_done;
		logic out_full;
	} ffba_stat_t;

endpackage

@@ rtl/ffba_ctrl.sv @@
module ffba_ctrl
	import ffba_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_req_type,
	input  logic       cfg_write,
	input  ffba_stat_t stat,
	output ffba_cmd_t  cmd,
	output logic       in_stall,
	output logic       cfg_ready
);

	ffba_state_t state_q, state_d;
	logic [1:0]  req_q;

	// track the request kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= REQ_ALLOC;
		end else if (in_valid && !in_stall) begin
			req_q <= in_req_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// accept register writes only between requests
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (cfg_write) state_d = S_CLEAR;
				else if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_write) state_d = S_CLEAR;
				else if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (req_q == REQ_ALLOC || req_q == REQ_INFO) state_d = S_SCAN;
				else if (stat.decode_ok) state_d = S_SCAN;
				else state_d = S_DONE;
			end
			S_SCAN:      state_d = S_SCAN_WAIT;
			S_SCAN_WAIT: begin
				if (stat.scan_done) begin
					if (req_q == REQ_FREE) state_d = S_PREV;
					else state_d = S_APPLY;
				end
			end
			S_PREV:      state_d = S_PREV_WAIT;
			S_PREV_WAIT: if (stat.prev_done) state_d = S_APPLY;
			S_APPLY:     state_d = S_DONE;
			S_DONE: begin
				if (!stat.out_full) state_d = S_IDLE;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				cmd.clear_start = cfg_write;
			end
			S_IDLE: begin
				in_stall = cfg_write;
				cmd.load_req = in_valid && !cfg_write;
				cmd.clear_start = cfg_write;
			end
			S_SCAN:      cmd.scan_start = 1'b1;
			S_SCAN_WAIT: cmd.scan_step = 1'b1;
			S_PREV:      cmd.prev_start = 1'b1;
			S_PREV_WAIT: cmd.prev_step = 1'b1;
			S_APPLY:     cmd.apply = 1'b1;
			S_DONE:      cmd.finish = !stat.out_full;
			default:     cmd = '0;
		endcase
	end

endmodule

@@ rtl/ffba_dp.sv @@
module ffba_dp
	import ffba_pkg::*;
#(
	parameter int POOL_WORDS = 4096,
	parameter int HEADER_WORDS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ffba_cmd_t   cmd,
	input  logic [1:0]  req_type,
	input  logic [14:0] request_size,
	input  logic [31:0] handle_in,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        out_stall,
	output ffba_stat_t  stat,
	output logic        out_valid,
	output logic [2:0]  status,
	output logic [31:0] handle_out,
	output logic [14:0] byte_count,
	output logic [14:0] total_bytes
);

	localparam int AW = $clog2(POOL_WORDS);
	localparam int CW = AW + 1;
	localparam int NEED_W = 14;
	localparam logic [CW-1:0] POOL_MAX = CW'(POOL_WORDS);
	localparam logic [CW-1:0] HDR = CW'(HEADER_WORDS);

	// mark memory: bit0 start, bit1 used
	logic [1:0]    mark_mem [POOL_WORDS];
	logic [1:0]    rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [1:0]    wr_data;

	logic [27:0]       base_q;
	logic [14:0]       bytes_q;
	logic [1:0]        req_q;
	logic [NEED_W-1:0] need_q;
	logic [27:0]       hlow_q;
	logic [3:0]        htag_q;
	logic              hzero_q;
	logic              szero_q;

	logic [CW-1:0] n_words;
	logic [CW-1:0] clr_q;
	logic [CW-1:0] w_q;
	logic [2:0]    dec_st;
	logic [27:0]   off;

	// scan walker
	logic [CW-1:0] pos_q, blk_q, found_q, next_q;
	logic          blk_used_q, found_v_q, pend_q, scan_done_q;
	logic [CW-1:0] sum_q;
	logic [CW-1:0] p_q;
	logic          prev_done_q, prev_used_q;
	logic          next_free_q;
	logic          first_q;
	logic          hit;
	logic [CW-1:0] blen;
	logic [CW-1:0] pos_prev_q;
	logic          rd_v_q;
	logic          prd_v_q;

	// update sequencing
	logic [CW-1:0] cut;
	logic          ap_split;
	logic [1:0]    apply_step_q;
	logic [AW-1:0] ap_addr0_q, ap_addr1_q, ap_addr2_q;
	logic [1:0]    ap_data0_q, ap_data1_q;
	logic          ap_en1_q, ap_en2_q;
	logic          merge;

	// working result and output word
	logic          applied_q;
	logic [27:0]   haddr;
	logic [2:0]    st_q;
	logic [31:0]   hout_q;
	logic [14:0]   cnt_q, tot_q;
	logic          out_v_q;
	logic [2:0]    res_st_q;
	logic [31:0]   res_hout_q;
	logic [14:0]   res_cnt_q, res_tot_q;

	always_comb begin
		if (bytes_q[14:2] > POOL_MAX) n_words = POOL_MAX;
		else n_words = CW'(bytes_q[14:2]);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			bytes_q <= 15'd16384;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_POOL_BASE) base_q <= cfg_data[27:0];
			else bytes_q <= cfg_data[14:0];
		end
	end

	// capture request word
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q   <= req_type;
			need_q  <= NEED_W'((17'(request_size) + 17'd3) >> 2);
			szero_q <= (request_size == '0);
			hzero_q <= (handle_in == '0);
			htag_q  <= handle_in[31:28];
			hlow_q  <= handle_in[27:0];
		end
	end

	// handle decode (start/used checked by scan of the block)
	assign off = hlow_q - {base_q[27:2], 2'b00};
	always_comb begin
		if (hzero_q) dec_st = ST_ZERO;
		else if (htag_q != TAG_MEM) dec_st = ST_BADTAG;
		else if (32'(off) >= 32'({n_words, 2'b00})) dec_st = ST_BADTAG;
		else if (off[1:0] != 2'b00) dec_st = ST_NOTUSED;
		else dec_st = ST_OK;
	end
	assign w_q = CW'(off[27:2]);

	// clearing pass pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_start) begin
			clr_q <= '0;
		end else if (cmd.clear_step && clr_q != POOL_MAX) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign stat.clear_last = (clr_q == POOL_MAX - 1'b1);

	// scan: walk words from 0, one read per cycle
	always_comb begin
		rd_addr = pos_q[AW-1:0];
		if (cmd.prev_start || cmd.prev_step) rd_addr = p_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		rd_q <= mark_mem[rd_addr];
		if (wr_en) mark_mem[wr_addr] <= wr_data;
	end

	// memory write arbitration
	assign cut = CW'(32'(found_q) + 32'(HDR) + 32'(need_q));
	assign ap_split = (next_q - cut) > HDR;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (cmd.clear_step) begin
			wr_en = (clr_q != POOL_MAX);
			wr_addr = clr_q[AW-1:0];
			wr_data = (clr_q == '0) ? 2'b01 : 2'b00;
		end else if (apply_step_q == 2'd1) begin
			wr_en = 1'b1;
			wr_addr = ap_addr0_q;
			wr_data = ap_data0_q;
		end else if (apply_step_q == 2'd2) begin
			wr_en = ap_en1_q;
			wr_addr = ap_addr1_q;
			wr_data = ap_data1_q;
		end else if (apply_step_q == 2'd3) begin
			wr_en = ap_en2_q;
			wr_addr = ap_addr2_q;
			wr_data = 2'b00;
		end
	end

	// scan over the pool; block bookkeeping
	assign blen = pos_prev_q - blk_q;
	always_comb begin
		hit = 1'b0;
		if (req_q == REQ_ALLOC)
			hit = !blk_used_q && (32'(blen) >= 32'(HDR) + 32'(need_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_done_q <= 1'b0;
			rd_v_q <= 1'b0;
		end else if (cmd.scan_start) begin
			pos_q       <= '0;
			rd_v_q      <= 1'b0;
			first_q     <= 1'b1;
			found_v_q   <= 1'b0;
			sum_q       <= '0;
			scan_done_q <= 1'b0;
			pend_q      <= 1'b0;
			next_free_q <= 1'b0;
		end else if (cmd.scan_step && !scan_done_q) begin
			rd_v_q <= 1'b1;
			pos_prev_q <= pos_q;
			if (pos_q != n_words) pos_q <= pos_q + 1'b1;
			if (rd_v_q) begin
				// rd_q is the mark of word pos_prev_q
				if (pos_prev_q == n_words || rd_q[0]) begin
					// block blk_q ends at pos_prev_q
					if (!first_q) begin
						if (req_q == REQ_INFO && !blk_used_q) sum_q <= sum_q + blen;
						if (hit && !found_v_q) begin
							found_v_q <= 1'b1;
							found_q <= blk_q;
							next_q <= pos_prev_q;
							scan_done_q <= 1'b1;
						end
						if (pend_q) begin
							next_q <= pos_prev_q;
							next_free_q <= (pos_prev_q != n_words) && !rd_q[1];
							scan_done_q <= 1'b1;
						end
					end
					if (pos_prev_q == n_words) scan_done_q <= 1'b1;
					first_q <= 1'b0;
					blk_q <= pos_prev_q;
					blk_used_q <= rd_q[1];
					if ((req_q == REQ_FREE || req_q == REQ_SIZE) && pos_prev_q == w_q) begin
						pend_q <= 1'b1;
						found_q <= pos_prev_q;
						found_v_q <= rd_q[1];
						if (!rd_q[1]) scan_done_q <= 1'b1;
					end
				end else if ((req_q == REQ_FREE || req_q == REQ_SIZE)
						&& pos_prev_q == w_q) begin
					found_v_q <= 1'b0;
					scan_done_q <= 1'b1;
				end
			end
		end
	end
	assign stat.scan_done = scan_done_q;
	assign stat.decode_ok = (dec_st == ST_OK);

	// previous block search for free (walk backward word by word)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_done_q <= 1'b0;
			prd_v_q <= 1'b0;
		end else if (cmd.prev_start) begin
			prev_done_q <= (found_q == '0) || !found_v_q;
			prev_used_q <= 1'b1;
			p_q <= found_q - 1'b1;
			prd_v_q <= 1'b0;
		end else if (cmd.prev_step && !prev_done_q) begin
			if (!prd_v_q) begin
				prd_v_q <= 1'b1;
			end else if (rd_q[0] || p_q == '0) begin
				prev_used_q <= rd_q[1];
				prev_done_q <= 1'b1;
			end else begin
				p_q <= p_q - 1'b1;
				prd_v_q <= 1'b0;
			end
		end
	end
	assign stat.prev_done = prev_done_q;

	// apply the update as up to three mark writes in sequence
	assign merge = (found_q != '0) && !prev_used_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apply_step_q <= '0;
		end else if (cmd.apply && found_v_q &&
				((req_q == REQ_ALLOC && !szero_q) || req_q == REQ_FREE)) begin
			apply_step_q <= 2'd1;
			ap_addr0_q <= found_q[AW-1:0];
			if (req_q == REQ_ALLOC) begin
				ap_data0_q <= 2'b11;
				ap_en1_q <= ap_split;
				ap_addr1_q <= cut[AW-1:0];
				ap_data1_q <= 2'b01;
				ap_en2_q <= 1'b0;
			end else begin
				ap_data0_q <= merge ? 2'b00 : 2'b01;
				ap_en1_q <= 1'b0;
				ap_addr1_q <= '0;
				ap_data1_q <= '0;
				ap_en2_q <= next_free_q;
			end
			ap_addr2_q <= next_q[AW-1:0];
		end else if (apply_step_q != '0) begin
			apply_step_q <= (apply_step_q == 2'd3) ? 2'd0 : apply_step_q + 1'b1;
		end
	end

	// working result
	assign haddr = {base_q[27:2], 2'b00} + 28'({found_q, 2'b00});

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			st_q <= ST_OK;
			hout_q <= '0;
			cnt_q <= '0;
			tot_q <= '0;
		end else if (cmd.apply) begin
			unique case (req_q)
				REQ_ALLOC: begin
					if (szero_q) st_q <= ST_ZERO;
					else if (found_v_q) begin
						st_q <= ST_OK;
						hout_q <= {TAG_MEM, haddr};
					end else st_q <= ST_NOMEM;
				end
				REQ_FREE: st_q <= found_v_q ? ST_OK : ST_NOTUSED;
				REQ_SIZE: begin
					st_q <= found_v_q ? ST_OK : ST_NOTUSED;
					if (found_v_q && (next_q - found_q) >= HDR)
						cnt_q <= 15'({next_q - found_q - HDR, 2'b00});
				end
				default: begin
					cnt_q <= 15'({sum_q, 2'b00});
					tot_q <= 15'({n_words, 2'b00});
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) applied_q <= 1'b0;
		else if (cmd.load_req) applied_q <= 1'b0;
		else if (cmd.apply) applied_q <= 1'b1;
	end

	// output word: load on finish, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.finish) begin
			out_v_q <= 1'b1;
		end else if (out_v_q && !out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_st_q   <= applied_q ? st_q : dec_st;
			res_hout_q <= hout_q;
			res_cnt_q  <= cnt_q;
			res_tot_q  <= tot_q;
		end
	end

	assign stat.out_full = out_v_q || (apply_step_q != '0);
	assign out_valid = out_v_q;
	assign status = res_st_q;
	assign handle_out = res_hout_q;
	assign byte_count = res_cnt_q;
	assign total_bytes = res_tot_q;

`ifndef ASSERT_OFF
	a_nomem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> handle_out == '0)
		else $error("failed result carries a handle");
	a_total_info: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_bytes != '0 |-> status == ST_OK)
		else $error("total on non-ok result");
	a_no_wr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> apply_step_q == '0)
		else $error("apply during clear");
`endif

endmodule

@@ rtl/first_fit_block_allocator_unit.sv @@
// First-fit block allocator with coalescing.
// Input channel (in_valid/in_stall) carries one request word: req_type,
// request_size, handle_in. Output channel (out_valid/out_stall) returns one
// result word per request: status, handle_out, byte_count, total_bytes.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// pool_base (index 0) or pool_bytes (index 1); each write reinitializes the
// pool. cfg_ready is high only while no request is in flight.
// The scan walks the block marks one word a cycle from word 0 and stops
// at the end of the block that decides the request (the pool end for
// info); free then walks backward to the previous block start. A handle
// rejected at decode returns without a scan.
// One request is in flight at a time; the next one is accepted in the cycle
// its predecessor's result becomes valid.
// Reset and each config write start a clearing pass over the mark memory;
// requests wait until it ends.
// A stalled result holds; the next request still runs and its result waits
// until the held word has been taken.
module first_fit_block_allocator_unit
	import ffba_pkg::*;
#(
	parameter int POOL_WORDS = 4096,
	parameter int HEADER_WORDS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [14:0] request_size,
	input  logic [31:0] handle_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] handle_out,
	output logic [14:0] byte_count,
	output logic [14:0] total_bytes,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	ffba_cmd_t  cmd;
	ffba_stat_t stat;

	ffba_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_req_type (req_type),
		.cfg_write   (cfg_valid),
		.stat        (stat),
		.cmd         (cmd),
		.in_stall    (in_stall),
		.cfg_ready   (cfg_ready)
	);

	ffba_dp #(
		.POOL_WORDS   (POOL_WORDS),
		.HEADER_WORDS (HEADER_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req_type),
		.request_size (request_size),
		.handle_in    (handle_in),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.stat         (stat),
		.out_valid    (out_valid),
		.status       (status),
		.handle_out   (handle_out),
		.byte_count   (byte_count),
		.total_bytes  (total_bytes)
	);

endmodule

@@ test/ffba_checker.sv @@
`timescale 1ns / 100ps

module ffba_checker
	import ffba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [14:0] request_size,
	input  logic [31:0] handle_in,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [31:0] handle_out,
	input  logic [14:0] byte_count,
	input  logic [14:0] total_bytes,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fails,
	output int          pending
);

	localparam int POOL_W = 4096;
	localparam int HDR_W  = 3;

	typedef struct {
		logic [2:0]  st;
		logic [31:0] hnd;
		logic [14:0] cnt;
		logic [14:0] tot;
	} alloc_result_t;

	// shadow of the pool: block start and used marks plus registers
	bit          start_mark [POOL_W];
	bit          used_mark  [POOL_W];
	logic [27:0] base_reg;
	logic [14:0] bytes_reg;

	alloc_result_t expected_results[$];

	function automatic void clear_pool();
		for (int k = 0; k < POOL_W; k++) begin
			start_mark[k] = 1'b0;
			used_mark[k]  = 1'b0;
		end
		start_mark[0] = 1'b1;
	endfunction

	function automatic int pool_words();
		int w;
		w = int'(bytes_reg) >> 2;
		return (w > POOL_W) ? POOL_W : w;
	endfunction

	function automatic int block_end(int i, int n);
		int j;
		j = i + 1;
		while (j < n && !start_mark[j])
			j++;
		return j;
	endfunction

	// map a handle to the word index of a used block; returns a status code
	function automatic logic [2:0] handle_to_word(logic [31:0] h, output int w);
		logic [27:0] off;
		w = 0;
		if (h == 32'd0)
			return ST_ZERO;
		if (h[31:28] != TAG_MEM)
			return ST_BADTAG;
		off = h[27:0] - {base_reg[27:2], 2'b00};
		if (off >= 28'(pool_words() * 4))
			return ST_BADTAG;
		if (off[1:0] != 2'b00)
			return ST_NOTUSED;
		w = int'(off >> 2);
		if (w >= POOL_W || !start_mark[w] || !used_mark[w])
			return ST_NOTUSED;
		return ST_OK;
	endfunction

	function automatic alloc_result_t serve_request(logic [1:0] rt, logic [14:0] sz,
			logic [31:0] h);
		alloc_result_t r;
		int n, i, e, w, need, cut, nxt, keep, p, sum;
		bit found;
		r.st = ST_OK;
		r.hnd = '0;
		r.cnt = '0;
		r.tot = '0;
		n = pool_words();
		case (rt)
			REQ_ALLOC: begin
				if (sz == 15'd0) begin
					r.st = ST_ZERO;
				end else begin
					need = (int'(sz) + 3) >> 2;
					r.st = ST_NOMEM;
					found = 1'b0;
					i = 0;
					while (i < n && !found) begin
						e = block_end(i, n);
						if (!used_mark[i] && e - i >= HDR_W + need) begin
							cut = i + HDR_W + need;
							used_mark[i] = 1'b1;
							// split only when the tail can hold more than a header
							if (e - cut > HDR_W) begin
								start_mark[cut] = 1'b1;
								used_mark[cut]  = 1'b0;
							end
							r.st = ST_OK;
							r.hnd = {TAG_MEM, 28'({base_reg[27:2], 2'b00} + 28'(i * 4))};
							found = 1'b1;
						end
						i = e;
					end
				end
			end
			REQ_FREE: begin
				r.st = handle_to_word(h, w);
				if (r.st == ST_OK) begin
					nxt = block_end(w, n);
					keep = w;
					used_mark[w] = 1'b0;
					// merge into a free block below
					if (w > 0) begin
						p = w - 1;
						while (p > 0 && !start_mark[p])
							p--;
						if (!used_mark[p]) begin
							start_mark[w] = 1'b0;
							keep = p;
						end
					end
					// absorb a free block above
					if (nxt < n && !used_mark[nxt])
						start_mark[nxt] = 1'b0;
					used_mark[keep] = 1'b0;
				end
			end
			REQ_SIZE: begin
				r.st = handle_to_word(h, w);
				if (r.st == ST_OK) begin
					e = block_end(w, n);
					r.cnt = (e - w >= HDR_W) ? 15'((e - w - HDR_W) * 4) : 15'd0;
				end
			end
			default: begin
				sum = 0;
				i = 0;
				while (i < n) begin
					e = block_end(i, n);
					if (!used_mark[i])
						sum += (e - i) * 4;
					i = e;
				end
				r.cnt = 15'(sum);
				r.tot = 15'(n * 4);
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t checker: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
		fails++;
	endtask

	initial begin
		fails = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			base_reg  = '0;
			bytes_reg = 15'd16384;
			clear_pool();
			expected_results.delete();
		end else begin
			// register write reinitializes the pool
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_POOL_BASE)
					base_reg = cfg_data[27:0];
				else
					bytes_reg = cfg_data[14:0];
				clear_pool();
			end
			// compare result word with the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result word, status", 32'(status), 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
					if (handle_out !== want.hnd)
						report_mismatch("handle_out", handle_out, want.hnd);
					if (byte_count !== want.cnt)
						report_mismatch("byte_count", 32'(byte_count), 32'(want.cnt));
					if (total_bytes !== want.tot)
						report_mismatch("total_bytes", 32'(total_bytes), 32'(want.tot));
				end
			end
			// predict for each accepted request word
			if (in_valid && !in_stall)
				expected_results.push_back(serve_request(req_type, request_size, handle_in));
		end
		pending = expected_results.size();
	end

endmodule

@@ test/tb_first_fit_block_allocator_unit.sv @@
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_unit;
	import ffba_pkg::*;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_INFO;
	logic [14:0] request_size = '0;
	logic [31:0] handle_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] handle_out;
	logic [14:0] byte_count;
	logic [14:0] total_bytes;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = CFG_POOL_BASE;
	logic [31:0] cfg_data = '0;

	int          fails;
	int          pending;

	logic [31:0] live_handles[$];
	logic [31:0] freed_handles[$];
	logic [27:0] cur_base = '0;
	int          cur_bytes = 16384;
	int          burst_left = 0;
	bit          want_hold = 1'b0;

	first_fit_block_allocator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .request_size(request_size), .handle_in(handle_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .handle_out(handle_out),
		.byte_count(byte_count), .total_bytes(total_bytes),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ffba_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .request_size(request_size), .handle_in(handle_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .handle_out(handle_out),
		.byte_count(byte_count), .total_bytes(total_bytes),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// hard limit on the run
	initial begin
		#200_000_000;
		$display("tb: failure");
		$finish;
	end

	// collect handles of successful allocations
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall && status == ST_OK && handle_out != 32'd0)
			live_handles.push_back(handle_out);

	// receiver: changing stall pattern, plus one long hold-off on request
	initial begin
		int mode, left, hold_left;
		bit hold_taken;
		mode = 0;
		left = 100;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (want_hold && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = 3000;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(50, 300);
			end
			left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= left[0];
				endcase
			end
		end
	end

	// offer one request word; called and returns at a falling edge
	task automatic send_word(logic [1:0] rt, logic [14:0] sz, logic [31:0] h);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		req_type <= rt;
		request_size <= sz;
		handle_in <= h;
		in_valid <= 1'b1;
		@(posedge clk iff !in_stall);
		@(negedge clk);
		burst_left--;
	endtask

	// stop offering and wait until every result word is back
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] value);
		drain();
		repeat (20) @(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk iff cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_POOL_BASE)
			cur_base = value[27:0];
		else
			cur_bytes = int'(value[14:0]);
		live_handles.delete();
		freed_handles.delete();
	endtask

	function automatic logic [31:0] noise_handle();
		int words;
		words = (cur_bytes >> 2 > 4096) ? 4096 : cur_bytes >> 2;
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return $urandom();
			2: return {4'(TAG_MEM), 28'($urandom())};
			3: return {4'(TAG_MEM), 28'({cur_base[27:2], 2'b00} + 28'($urandom_range(0,
				words * 4 + 8)))};
			default: return {4'(TAG_MEM), 28'({cur_base[27:2], 2'b00} +
				28'($urandom_range(0, words) * 4))};
		endcase
	endfunction

	function automatic logic [31:0] pick_handle(bit release_it);
		int k;
		logic [31:0] h;
		if (live_handles.size() > 0 && $urandom_range(0, 9) < 7) begin
			k = $urandom_range(0, live_handles.size() - 1);
			h = live_handles[k];
			if (release_it) begin
				live_handles.delete(k);
				freed_handles.push_back(h);
				if (freed_handles.size() > 32)
					void'(freed_handles.pop_front());
			end
			return h;
		end
		if (freed_handles.size() > 0 && $urandom_range(0, 2) == 0)
			return freed_handles[$urandom_range(0, freed_handles.size() - 1)];
		return noise_handle();
	endfunction

	task automatic random_requests(int count, bit with_hold);
		int roll, cap;
		logic [14:0] sz;
		cap = (cur_bytes / 8 > 4) ? cur_bytes / 8 : 4;
		for (int k = 0; k < count; k++) begin
			if (k % 60 == 59)
				drain();
			if (with_hold && k == count / 2)
				want_hold = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				case ($urandom_range(0, 9))
					0: sz = 15'($urandom());
					1, 2: sz = 15'($urandom_range(0, 48));
					default: sz = 15'($urandom_range(1, cap));
				endcase
				send_word(REQ_ALLOC, sz, $urandom());
			end else if (roll < 75) begin
				send_word(REQ_FREE, 15'($urandom()), pick_handle(1'b1));
			end else if (roll < 90) begin
				send_word(REQ_SIZE, 15'($urandom()), pick_handle(1'b0));
			end else begin
				send_word(REQ_INFO, 15'($urandom()), $urandom());
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, error codes, split and merge, at reset config
		send_word(REQ_INFO, '0, '0);
		send_word(REQ_ALLOC, 15'd0, '0);
		send_word(REQ_ALLOC, 15'd1, '0);
		send_word(REQ_ALLOC, 15'd8, '0);
		send_word(REQ_ALLOC, 15'd4, '0);
		send_word(REQ_ALLOC, 15'h7FFF, 32'hFFFF_FFFF);
		send_word(REQ_ALLOC, 15'd16384, '0);
		drain();
		send_word(REQ_SIZE, '0, 32'h2000_0000);
		send_word(REQ_SIZE, '0, 32'd0);
		send_word(REQ_FREE, '0, 32'hF000_0000);
		send_word(REQ_FREE, '0, 32'h1000_0010);
		send_word(REQ_FREE, '0, 32'h2000_4000);
		send_word(REQ_FREE, '0, 32'h2000_0002);
		send_word(REQ_FREE, '0, 32'h2000_0004);
		// free outer blocks, then the middle one merges on both sides
		send_word(REQ_FREE, '0, 32'h2000_0000);
		send_word(REQ_FREE, '0, 32'h2000_0024);
		send_word(REQ_FREE, '0, 32'h2000_0010);
		send_word(REQ_FREE, '0, 32'h2000_0010);
		send_word(REQ_SIZE, '0, 32'h2000_0010);
		send_word(REQ_INFO, '0, '0);
		// whole pool in one block: tail is not split
		send_word(REQ_ALLOC, 15'd16372, '0);
		send_word(REQ_INFO, '0, '0);
		send_word(REQ_SIZE, '0, 32'h2000_0000);
		send_word(REQ_FREE, '0, 32'h2000_0000);
		drain();
		live_handles.delete();

		// highest base, handles wrap in 28 bits
		write_reg(CFG_POOL_BASE, {4'($urandom()), 28'hFFF_FFFC});
		write_reg(CFG_POOL_BYTES, {17'($urandom()), 15'd256});
		random_requests(150, 1'b0);
		// pool no larger than a header
		write_reg(CFG_POOL_BASE, $urandom());
		write_reg(CFG_POOL_BYTES, 32'd12);
		random_requests(30, 1'b0);
		// oversized register is capped
		write_reg(CFG_POOL_BYTES, 32'h0000_7FFF);
		random_requests(12, 1'b0);
		write_reg(CFG_POOL_BASE, $urandom());
		write_reg(CFG_POOL_BYTES, 32'd512);
		random_requests(180, 1'b1);
		write_reg(CFG_POOL_BASE, 32'd0);
		write_reg(CFG_POOL_BYTES, 32'd64);
		random_requests(120, 1'b0);
		write_reg(CFG_POOL_BASE, $urandom());
		write_reg(CFG_POOL_BYTES, 32'($urandom_range(12, 1024)));
		random_requests(110, 1'b0);

		drain();
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ffba_pkg.sv
rtl/ffba_ctrl.sv
rtl/ffba_dp.sv
rtl/first_fit_block_allocator_unit.sv
test/ffba_checker.sv
test/tb_first_fit_block_allocator_unit.sv
